// ===== sv/bcld_pkg.sv =====
`default_nettype none

package bcld_pkg;

    localparam int ENTRIES       = 16;
    localparam int BLOCK_BITS    = 24;
    localparam int ADDR_BITS     = 48;
    localparam int VERSION_BITS  = 8;

    localparam int SECTORS_BITS  = 39;
    localparam int SECTOR_SHIFT  = 9;
    localparam int STAMP_BITS    = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== sv/bcld_ram.sv =====
`default_nettype none

module bcld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/block_cache_lru_directory_top.sv =====
// Tag directory of a fully associative block cache with LRU replacement.
// Input channel (s_): one lookup request per transfer carrying the object
// version, the byte offset and the object length in 512-byte sectors.
// Output channel (m_): one result per request with the slot, the aligned
// block start, the offset inside the block, the fill length on a miss and
// the bytes available; hit and out_of_range travel in m_tuser.
// Each request scans the directory memory one entry per cycle through its
// single read port, then writes the chosen entry back and moves the result
// to the output register before the next request is accepted.
// The result sits in an output register; a new request is accepted while it
// waits. If the receiver stalls, the next result waits in its own stage and
// no further request is taken until the output register frees up.
// Reset clears all valid bits, the use counter and m_tvalid; the block leaves
// reset idle and ready for a request. The directory memory needs no clearing
// pass.
`default_nettype none

module block_cache_lru_directory_top #(
    parameter int ENTRIES      = bcld_pkg::ENTRIES,
    parameter int BLOCK_BITS   = bcld_pkg::BLOCK_BITS,
    parameter int ADDR_BITS    = bcld_pkg::ADDR_BITS,
    parameter int VERSION_BITS = bcld_pkg::VERSION_BITS
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic s_tvalid,
    output logic      s_tready,
    // object_version, request_offset, object_sectors
    input  wire logic [((VERSION_BITS + ADDR_BITS + bcld_pkg::SECTORS_BITS + 7) / 8) * 8 - 1:0]
                      s_tdata,

    output logic      m_tvalid,
    input  wire logic m_tready,
    // slot, block_start, offset_in_block, fetch_length, bytes_available
    output logic [(($clog2(ENTRIES) + ADDR_BITS + 3 * BLOCK_BITS + 2 + 7) / 8) * 8 - 1:0]
                      m_tdata,
    // hit, out_of_range
    output logic [1:0] m_tuser
);

    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int BLK_W   = ADDR_BITS - BLOCK_BITS;
    localparam int LEN_W   = BLOCK_BITS + 1;
    localparam int STAMP_W = bcld_pkg::STAMP_BITS;
    localparam int SEC_W   = bcld_pkg::SECTORS_BITS;
    localparam int END_W   = SEC_W + bcld_pkg::SECTOR_SHIFT;
    localparam int CMP_W   = (ADDR_BITS > END_W) ? ADDR_BITS : END_W;
    localparam int MEM_W   = BLK_W + VERSION_BITS + STAMP_W + LEN_W;
    localparam int IN_W    = ((VERSION_BITS + ADDR_BITS + SEC_W + 7) / 8) * 8;
    localparam int OUT_USED = SLOT_W + ADDR_BITS + BLOCK_BITS + 2 * LEN_W;
    localparam int OUT_W   = ((OUT_USED + 7) / 8) * 8;

    localparam int VER_LO   = BLK_W;
    localparam int STAMP_LO = VER_LO + VERSION_BITS;
    localparam int LEN_LO   = STAMP_LO + STAMP_W;

    bcld_pkg::state_t state_reg, state_next;

    logic [VERSION_BITS-1:0] ver_reg;
    logic [ADDR_BITS-1:0]    off_reg;
    logic [SEC_W-1:0]        sectors_reg;

    logic [SLOT_W-1:0]  idx_reg;
    logic               hit_reg;
    logic [SLOT_W-1:0]  hit_slot_reg;
    logic [LEN_W-1:0]   hit_len_reg;
    logic               inval_reg;
    logic [SLOT_W-1:0]  inval_slot_reg;
    logic [STAMP_W-1:0] least_reg;
    logic [SLOT_W-1:0]  min_slot_reg;
    logic [LEN_W-1:0]   fetch_reg;
    logic               oor_reg;

    logic [ENTRIES-1:0] valid_reg;
    logic [STAMP_W-1:0] use_counter_reg;

    logic               res_hit_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic [LEN_W-1:0]   res_fetch_reg;
    logic [LEN_W-1:0]   res_avail_reg;
    logic               res_oor_reg;

    logic               m_tvalid_reg;
    logic               out_hit_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [ADDR_BITS-1:0] out_start_reg;
    logic [BLOCK_BITS-1:0] out_inner_reg;
    logic [LEN_W-1:0]   out_fetch_reg;
    logic [LEN_W-1:0]   out_avail_reg;
    logic               out_oor_reg;

    logic               in_accept;
    logic               out_load;
    logic [SLOT_W-1:0]  rd_addr;
    logic [MEM_W-1:0]   rd_data;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_slot;
    logic [MEM_W-1:0]   wr_data;

    logic [BLK_W-1:0]        rd_blk;
    logic [VERSION_BITS-1:0] rd_ver;
    logic [STAMP_W-1:0]      rd_stamp;
    logic [LEN_W-1:0]        rd_len;
    logic                    rd_valid;

    logic [BLK_W-1:0]      cur_blk;
    logic [BLOCK_BITS-1:0] cur_inner;
    logic [CMP_W-1:0]      off_ext;
    logic [CMP_W-1:0]      start_ext;
    logic [CMP_W-1:0]      end_ext;
    logic [CMP_W-1:0]      diff;
    logic [LEN_W-1:0]      fetch_calc;
    logic [LEN_W-1:0]      len_sel;
    logic [LEN_W-1:0]      avail_calc;

    bcld_ram #(
        .WIDTH (MEM_W),
        .DEPTH (ENTRIES)
    ) u_dir_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (wr_slot),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_blk   = rd_data[BLK_W-1:0];
    assign rd_ver   = rd_data[VER_LO +: VERSION_BITS];
    assign rd_stamp = rd_data[STAMP_LO +: STAMP_W];
    assign rd_len   = rd_data[LEN_LO +: LEN_W];
    assign rd_valid = valid_reg[idx_reg];

    assign cur_blk   = off_reg[ADDR_BITS-1:BLOCK_BITS];
    assign cur_inner = off_reg[BLOCK_BITS-1:0];
    assign off_ext   = CMP_W'(off_reg);
    assign start_ext = CMP_W'({cur_blk, {BLOCK_BITS{1'b0}}});
    assign end_ext   = CMP_W'({sectors_reg, {bcld_pkg::SECTOR_SHIFT{1'b0}}});
    assign diff      = end_ext - start_ext;

    always_comb begin
        if (end_ext <= start_ext) begin
            fetch_calc = '0;
        end else if (diff[CMP_W-1:BLOCK_BITS] == '0) begin
            fetch_calc = LEN_W'(diff[BLOCK_BITS-1:0]);
        end else begin
            fetch_calc = {1'b1, {BLOCK_BITS{1'b0}}};
        end
    end

    always_comb begin
        if (hit_reg) begin
            wr_slot = hit_slot_reg;
        end else if (inval_reg) begin
            wr_slot = inval_slot_reg;
        end else begin
            wr_slot = min_slot_reg;
        end
        len_sel = hit_reg ? hit_len_reg : fetch_reg;
        if (oor_reg || (len_sel <= LEN_W'(cur_inner))) begin
            avail_calc = '0;
        end else begin
            avail_calc = len_sel - LEN_W'(cur_inner);
        end
    end

    assign wr_data = {len_sel, use_counter_reg, ver_reg, cur_blk};

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        wr_en      = 1'b0;
        out_load   = 1'b0;
        rd_addr    = '0;
        case (state_reg)
            bcld_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = bcld_pkg::ST_SCAN;
                end
            end
            bcld_pkg::ST_SCAN: begin
                rd_addr = idx_reg + SLOT_W'(1);
                if (idx_reg == SLOT_W'(ENTRIES - 1)) begin
                    state_next = bcld_pkg::ST_WRITE;
                end
            end
            bcld_pkg::ST_WRITE: begin
                wr_en      = 1'b1;
                state_next = bcld_pkg::ST_EMIT;
            end
            bcld_pkg::ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = bcld_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bcld_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bcld_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            use_counter_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_slot] <= 1'b1;
            use_counter_reg    <= use_counter_reg + STAMP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ver_reg        <= s_tdata[VERSION_BITS-1:0];
            off_reg        <= s_tdata[VERSION_BITS +: ADDR_BITS];
            sectors_reg    <= s_tdata[VERSION_BITS + ADDR_BITS +: SEC_W];
            idx_reg        <= '0;
            hit_reg        <= 1'b0;
            inval_reg      <= 1'b0;
            least_reg      <= use_counter_reg;
            min_slot_reg   <= '0;
        end else if (state_reg == bcld_pkg::ST_SCAN) begin
            idx_reg   <= idx_reg + SLOT_W'(1);
            fetch_reg <= fetch_calc;
            oor_reg   <= off_ext >= end_ext;
            if (rd_valid && !hit_reg && rd_blk == cur_blk && rd_ver == ver_reg) begin
                hit_reg      <= 1'b1;
                hit_slot_reg <= idx_reg;
                hit_len_reg  <= rd_len;
            end
            if (!rd_valid && !inval_reg) begin
                inval_reg      <= 1'b1;
                inval_slot_reg <= idx_reg;
            end
            if (rd_valid && rd_stamp < least_reg) begin
                least_reg    <= rd_stamp;
                min_slot_reg <= idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            res_hit_reg   <= hit_reg;
            res_slot_reg  <= wr_slot;
            res_fetch_reg <= hit_reg ? '0 : fetch_reg;
            res_avail_reg <= avail_calc;
            res_oor_reg   <= oor_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_hit_reg   <= res_hit_reg;
            out_slot_reg  <= res_slot_reg;
            out_start_reg <= {cur_blk, {BLOCK_BITS{1'b0}}};
            out_inner_reg <= cur_inner;
            out_fetch_reg <= res_fetch_reg;
            out_avail_reg <= res_avail_reg;
            out_oor_reg   <= res_oor_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({out_avail_reg, out_fetch_reg, out_inner_reg,
                              out_start_reg, out_slot_reg});
    assign m_tuser  = {out_oor_reg, out_hit_reg};

    a_counter_step: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bcld_pkg::ST_WRITE |=>
            use_counter_reg == $past(use_counter_reg) + STAMP_W'(1))
        else $error("use counter did not advance on write-back");

    a_scan_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> state_reg == bcld_pkg::ST_SCAN && idx_reg == '0)
        else $error("scan did not start at entry zero");

    a_hit_no_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_hit_reg |-> out_fetch_reg == '0)
        else $error("hit result carries a fill length");

    a_oor_no_avail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_oor_reg |-> out_avail_reg == '0)
        else $error("out-of-range result reports available bytes");

    a_slot_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bcld_pkg::ST_WRITE |=> valid_reg[$past(wr_slot)])
        else $error("written entry not marked valid");

endmodule

`default_nettype wire
